[rtl/single_source_shortest_paths_assert.svh]
// Assertion macros for the shortest-path block.
// Expects clk_i and rst_ni in the scope of each use.
`ifndef SINGLE_SOURCE_SHORTEST_PATHS_ASSERT_SVH
`define SINGLE_SOURCE_SHORTEST_PATHS_ASSERT_SVH

// same-cycle implication
`define SSP_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("shortest path assertion failed");

// next-cycle implication
`define SSP_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("shortest path assertion failed");

`endif

[rtl/ssp_pkg.sv]
// Shared sizes, codes and memory entry types of the shortest-path block.
// No dependencies.
`default_nettype none
package ssp_pkg;
  localparam int MAX_NODES = 1024;
  localparam int MAX_EDGES = 4096;
  localparam int NODE_W    = 11;
  localparam int WEIGHT_W  = 32;
  localparam int DIST_W    = 48;
  localparam int NODE_AW   = $clog2(MAX_NODES);
  localparam int EDGE_AW   = $clog2(MAX_EDGES);
  localparam int CNT_W     = $clog2(MAX_NODES + 2);
  localparam int EC_W      = $clog2(MAX_EDGES + 1);

  localparam logic [1:0] ACT_CLEAR = 2'd0;
  localparam logic [1:0] ACT_LOAD  = 2'd1;
  localparam logic [1:0] ACT_RUN   = 2'd2;
  localparam logic [1:0] ACT_QUERY = 2'd3;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_FULL      = 2'd1;
  localparam logic [1:0] ST_BAD_NODE  = 2'd2;

  typedef struct packed {
    logic [NODE_W-1:0]   src;
    logic [NODE_W-1:0]   tgt;
    logic [WEIGHT_W-1:0] weight;
  } edge_t;

  typedef struct packed {
    logic              reached;
    logic              settled;
    logic [DIST_W-1:0] path_len;
  } node_t;
endpackage
`default_nettype wire

[rtl/ssp_in_if.sv]
// Request channel of the shortest-path block: valid/ready plus item fields.
// Depends on ssp_pkg.
`default_nettype none
interface ssp_in_if;
  import ssp_pkg::*;
  logic              valid;
  logic              ready;
  logic [1:0]        action;
  logic [NODE_W-1:0] from_node;
  logic [NODE_W-1:0] to_node;
  logic [WEIGHT_W-1:0] edge_weight;
  logic [NODE_W-1:0] query_node;

  modport source (output valid, action, from_node, to_node, edge_weight, query_node,
                  input ready);
  modport sink   (input valid, action, from_node, to_node, edge_weight, query_node,
                  output ready);
endinterface
`default_nettype wire

[rtl/ssp_out_if.sv]
// Result channel of the shortest-path block: valid/ready plus result fields.
// Depends on ssp_pkg.
`default_nettype none
interface ssp_out_if;
  import ssp_pkg::*;
  logic              valid;
  logic              ready;
  logic [1:0]        status;
  logic [DIST_W-1:0] distance;
  logic              reachable;

  modport source (output valid, status, distance, reachable, input ready);
  modport sink   (input valid, status, distance, reachable, output ready);
endinterface
`default_nettype wire

[rtl/ssp_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`default_nettype none
module ssp_ram #(
  parameter int W  = 8,
  parameter int D  = 16,
  parameter int AW = $clog2(D)
) (
  input  wire logic          clk_i,
  input  wire logic          we_i,
  input  wire logic [AW-1:0] waddr_i,
  input  wire logic [W-1:0]  wdata_i,
  input  wire logic          re_i,
  input  wire logic [AW-1:0] raddr_i,
  output logic      [W-1:0]  rdata_o
);
  logic [W-1:0] mem_q [D];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end
endmodule
`default_nettype wire

[rtl/single_source_shortest_paths.sv]
// Shortest distances from node 1 over a loaded edge store.
// Depends on ssp_pkg, ssp_in_if, ssp_out_if, ssp_ram and the assertion header.
//
// Usage:
//  - in_i carries one item per beat: clear, load edge, run or query. out_o
//    returns exactly one result beat per item, in order.
//  - node_count_i is written when node_count_we_i is high; the user writes it
//    only while idle, which the block itself does not enforce.
//  - Clear and load: result next cycle; one item per cycle unless stalled.
//  - Query: node memory read, then result register; no item taken meanwhile.
//  - Run: a sweep over all MAX_NODES entries clears the node memory, then per
//    settled node a scan over the active nodes and, for every loaded edge, an
//    edge memory read, then a node read-modify-write if it leaves that node.
//    No item is taken until the run's result is out.
//  - Reset empties the edge store, sets node_count to 1024 and marks that
//    no run has happened, so queries report unreached nodes.
//  - A stalled receiver holds the result register; the next item is taken
//    in the cycle the waiting result drains.
`default_nettype none
`include "single_source_shortest_paths_assert.svh"
module single_source_shortest_paths (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     node_count_we_i,
  input  wire logic [ssp_pkg::NODE_W-1:0] node_count_i,
  ssp_in_if.sink                        in_i,
  ssp_out_if.source                     out_o
);
  import ssp_pkg::*;

  typedef enum logic [9:0] {
    S_IDLE   = 10'b0000000001,
    S_QRESP  = 10'b0000000010,
    S_CLR    = 10'b0000000100,
    S_SEED   = 10'b0000001000,
    S_SRCH   = 10'b0000010000,
    S_SETTLE = 10'b0000100000,
    S_ERD    = 10'b0001000000,
    S_ECHK   = 10'b0010000000,
    S_NUPD   = 10'b0100000000,
    S_DONE   = 10'b1000000000
  } state_e;

  state_e              state_q, state_d;
  logic [NODE_W-1:0]   node_count_q;
  logic [EC_W-1:0]     edges_q, edges_d;
  logic                ran_q, ran_d;
  logic [NODE_AW-1:0]  clr_q, clr_d;
  logic [CNT_W-1:0]    iss_q, iss_d;
  logic                rv_q, rv_d;
  logic [CNT_W-1:0]    rnode_q, rnode_d;
  logic                found_q, found_d;
  logic [CNT_W-1:0]    best_q, best_d;
  logic [DIST_W-1:0]   bestd_q, bestd_d;
  logic [EC_W-1:0]     e_q, e_d;
  logic                out_valid_q, out_valid_d;
  logic [1:0]          out_status_q, out_status_d;
  logic [DIST_W-1:0]   out_dist_q, out_dist_d;
  logic                out_reach_q, out_reach_d;

  logic [CNT_W-1:0]    cnt;
  logic                acc;
  logic                from_ok, to_ok, q_ok, tgt_ok;
  logic [DIST_W-1:0]   cand;

  // memory ports
  logic                e_we, e_re;
  logic [EDGE_AW-1:0]  e_waddr, e_raddr;
  edge_t               e_wdata, e_rdata;
  logic                n_we, n_re;
  logic [NODE_AW-1:0]  n_waddr, n_raddr;
  node_t               n_wdata, n_rdata;

  ssp_ram #(.W($bits(edge_t)), .D(MAX_EDGES)) u_edge_ram (
    .clk_i(clk_i), .we_i(e_we), .waddr_i(e_waddr), .wdata_i(e_wdata),
    .re_i(e_re), .raddr_i(e_raddr), .rdata_o(e_rdata)
  );

  ssp_ram #(.W($bits(node_t)), .D(MAX_NODES)) u_node_ram (
    .clk_i(clk_i), .we_i(n_we), .waddr_i(n_waddr), .wdata_i(n_wdata),
    .re_i(n_re), .raddr_i(n_raddr), .rdata_o(n_rdata)
  );

  // active node count, capped at MAX_NODES
  assign cnt = (32'(node_count_q) > MAX_NODES) ? CNT_W'(MAX_NODES) : CNT_W'(node_count_q);

  assign from_ok = (in_i.from_node != '0) && (32'(in_i.from_node) <= 32'(cnt));
  assign to_ok   = (in_i.to_node != '0) && (32'(in_i.to_node) <= 32'(cnt));
  assign q_ok    = (in_i.query_node != '0) && (32'(in_i.query_node) <= 32'(cnt));
  assign tgt_ok  = (e_rdata.tgt != '0) && (32'(e_rdata.tgt) <= 32'(cnt));
  assign cand    = bestd_q + DIST_W'(e_rdata.weight);

  assign in_i.ready = (state_q == S_IDLE) && (!out_valid_q || out_o.ready);
  assign acc        = in_i.valid && in_i.ready;

  assign out_o.valid     = out_valid_q;
  assign out_o.status    = out_status_q;
  assign out_o.distance  = out_dist_q;
  assign out_o.reachable = out_reach_q;

  // control: item decode and the graph walk sequencer
  always_comb begin
    state_d      = state_q;
    edges_d      = edges_q;
    ran_d        = ran_q;
    clr_d        = clr_q;
    iss_d        = iss_q;
    rv_d         = 1'b0;
    rnode_d      = rnode_q;
    found_d      = found_q;
    best_d       = best_q;
    bestd_d      = bestd_q;
    e_d          = e_q;
    out_valid_d  = out_valid_q && !out_o.ready;
    out_status_d = out_status_q;
    out_dist_d   = out_dist_q;
    out_reach_d  = out_reach_q;
    e_we    = 1'b0;
    e_waddr = EDGE_AW'(edges_q);
    e_wdata = '{src: in_i.from_node, tgt: in_i.to_node, weight: in_i.edge_weight};
    e_re    = 1'b0;
    e_raddr = EDGE_AW'(e_q);
    n_we    = 1'b0;
    n_waddr = clr_q;
    n_wdata = '0;
    n_re    = 1'b0;
    n_raddr = NODE_AW'(in_i.query_node - 1'b1);

    case (state_q)
      S_IDLE: begin
        if (acc) begin
          out_status_d = ST_OK;
          out_dist_d   = '0;
          out_reach_d  = 1'b0;
          case (in_i.action)
            ACT_CLEAR: begin
              edges_d     = '0;
              out_valid_d = 1'b1;
            end
            ACT_LOAD: begin
              out_valid_d = 1'b1;
              if (!from_ok || !to_ok) begin
                out_status_d = ST_BAD_NODE;
              end else if (32'(edges_q) >= MAX_EDGES) begin
                out_status_d = ST_FULL;
              end else begin
                e_we    = 1'b1;
                edges_d = edges_q + 1'b1;
              end
            end
            ACT_RUN: begin
              clr_d   = '0;
              state_d = S_CLR;
            end
            default: begin
              if (q_ok) begin
                n_re    = 1'b1;
                state_d = S_QRESP;
              end else begin
                out_valid_d  = 1'b1;
                out_status_d = ST_BAD_NODE;
                out_dist_d   = '1;
              end
            end
          endcase
        end
      end
      S_QRESP: begin
        out_valid_d = 1'b1;
        if (ran_q && n_rdata.reached) begin
          out_dist_d  = n_rdata.path_len;
          out_reach_d = 1'b1;
        end else begin
          out_dist_d  = '1;
          out_reach_d = 1'b0;
        end
        state_d = S_IDLE;
      end
      // wipe reached and settled marks of every node
      S_CLR: begin
        n_we    = 1'b1;
        n_waddr = clr_q;
        clr_d   = clr_q + 1'b1;
        if (clr_q == NODE_AW'(MAX_NODES - 1)) begin
          state_d = (cnt == '0) ? S_DONE : S_SEED;
        end
      end
      S_SEED: begin
        n_we    = 1'b1;
        n_waddr = '0;
        n_wdata = '{reached: 1'b1, settled: 1'b0, path_len: '0};
        iss_d   = CNT_W'(1);
        found_d = 1'b0;
        state_d = S_SRCH;
      end
      // pipelined min-search: issue a node read, compare its data in the next cycle
      S_SRCH: begin
        if (32'(iss_q) <= 32'(cnt)) begin
          n_re    = 1'b1;
          n_raddr = NODE_AW'(iss_q - 1'b1);
          iss_d   = iss_q + 1'b1;
          rv_d    = 1'b1;
          rnode_d = iss_q;
        end
        if (rv_q && n_rdata.reached && !n_rdata.settled &&
            (!found_q || n_rdata.path_len < bestd_q)) begin
          found_d = 1'b1;
          best_d  = rnode_q;
          bestd_d = n_rdata.path_len;
        end
        if (32'(iss_q) > 32'(cnt) && !rv_q) begin
          state_d = found_q ? S_SETTLE : S_DONE;
        end
      end
      S_SETTLE: begin
        n_we    = 1'b1;
        n_waddr = NODE_AW'(best_q - 1'b1);
        n_wdata = '{reached: 1'b1, settled: 1'b1, path_len: bestd_q};
        e_d     = '0;
        state_d = S_ERD;
      end
      // walk the edge store
      S_ERD: begin
        if (e_q < edges_q) begin
          e_re    = 1'b1;
          state_d = S_ECHK;
        end else begin
          iss_d   = CNT_W'(1);
          found_d = 1'b0;
          state_d = S_SRCH;
        end
      end
      S_ECHK: begin
        if (32'(e_rdata.src) == 32'(best_q) && tgt_ok) begin
          n_re    = 1'b1;
          n_raddr = NODE_AW'(e_rdata.tgt - 1'b1);
          state_d = S_NUPD;
        end else begin
          e_d     = e_q + 1'b1;
          state_d = S_ERD;
        end
      end
      // relax one edge: target read-modify-write
      S_NUPD: begin
        if (!n_rdata.reached || cand < n_rdata.path_len) begin
          n_we    = 1'b1;
          n_waddr = NODE_AW'(e_rdata.tgt - 1'b1);
          n_wdata = '{reached: 1'b1, settled: n_rdata.settled, path_len: cand};
        end
        e_d     = e_q + 1'b1;
        state_d = S_ERD;
      end
      S_DONE: begin
        ran_d        = 1'b1;
        out_valid_d  = 1'b1;
        out_status_d = ST_OK;
        out_dist_d   = '0;
        out_reach_d  = 1'b0;
        state_d      = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      node_count_q <= NODE_W'(1024);
      edges_q      <= '0;
      ran_q        <= 1'b0;
      rv_q         <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      if (node_count_we_i) begin
        node_count_q <= node_count_i;
      end
      edges_q     <= edges_d;
      ran_q       <= ran_d;
      rv_q        <= rv_d;
      out_valid_q <= out_valid_d;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    clr_q        <= clr_d;
    iss_q        <= iss_d;
    rnode_q      <= rnode_d;
    found_q      <= found_d;
    best_q       <= best_d;
    bestd_q      <= bestd_d;
    e_q          <= e_d;
    out_status_q <= out_status_d;
    out_dist_q   <= out_dist_d;
    out_reach_q  <= out_reach_d;
  end

  `SSP_ASSERT_NOW(a_ready_idle, in_i.ready, state_q == S_IDLE)
  `SSP_ASSERT_NOW(a_edges_bound, 1'b1, 32'(edges_q) <= MAX_EDGES)
  `SSP_ASSERT_NOW(a_done_slot_free, state_q == S_DONE, !out_valid_q)
  `SSP_ASSERT_NEXT(a_query_resp, state_q == S_QRESP, out_valid_q && state_q == S_IDLE)
endmodule
`default_nettype wire

[sim/single_source_shortest_paths_tb.sv]
// Self-checking testbench for the shortest-path block: edge loads, runs and queries.
// Depends on ssp_pkg, ssp_in_if, ssp_out_if and the RTL top level.
`default_nettype none
module single_source_shortest_paths_tb;
  import ssp_pkg::*;

  typedef struct packed {
    logic [1:0]        status;
    logic [DIST_W-1:0] distance;
    logic              reachable;
  } path_result_t;

  localparam logic [DIST_W-1:0] UNREACHED = {DIST_W{1'b1}};
  localparam longint CYCLE_LIMIT = 64'd150_000_000;

  // Path calculator and expected-result store
  class path_scoreboard;
    logic [NODE_W-1:0]   src_q [MAX_EDGES];
    logic [NODE_W-1:0]   tgt_q [MAX_EDGES];
    logic [WEIGHT_W-1:0] wgt_q [MAX_EDGES];
    int                  n_edges;
    logic [DIST_W-1:0]   node_dist [MAX_NODES+1];
    bit                  reached [MAX_NODES+1];
    bit                  settled [MAX_NODES+1];
    int                  nodes;
    path_result_t        pending [$];
    int                  errors;

    function new();
      n_edges = 0;
      nodes = 1024;
      errors = 0;
      for (int i = 0; i <= MAX_NODES; i++) reached[i] = 0;
    endfunction

    function int active();
      return (nodes > MAX_NODES) ? MAX_NODES : nodes;
    endfunction

    function void solve_paths();
      int cnt;
      int u;
      logic [DIST_W:0] d;
      cnt = active();
      for (int i = 0; i <= MAX_NODES; i++) begin
        reached[i] = 0;
        settled[i] = 0;
      end
      if (cnt < 1) return;
      node_dist[1] = 0;
      reached[1] = 1;
      forever begin
        u = 0;
        for (int v = 1; v <= cnt; v++)
          if (reached[v] && !settled[v] && (u == 0 || node_dist[v] < node_dist[u])) u = v;
        if (u == 0) break;
        settled[u] = 1;
        for (int e = 0; e < n_edges; e++) begin
          if (src_q[e] != u || tgt_q[e] < 1 || tgt_q[e] > cnt) continue;
          d = node_dist[u] + wgt_q[e];
          if (!reached[tgt_q[e]] || d < node_dist[tgt_q[e]]) begin
            node_dist[tgt_q[e]] = d[DIST_W-1:0];
            reached[tgt_q[e]] = 1;
          end
        end
      end
    endfunction

    // note one accepted input beat
    function void note_item(logic [1:0] act, logic [NODE_W-1:0] f, logic [NODE_W-1:0] t,
                            logic [WEIGHT_W-1:0] w, logic [NODE_W-1:0] q);
      path_result_t r;
      int cnt;
      cnt = active();
      r = '0;
      case (act)
        ACT_CLEAR: n_edges = 0;
        ACT_LOAD: begin
          if (f < 1 || f > cnt || t < 1 || t > cnt) r.status = ST_BAD_NODE;
          else if (n_edges >= MAX_EDGES) r.status = ST_FULL;
          else begin
            src_q[n_edges] = f;
            tgt_q[n_edges] = t;
            wgt_q[n_edges] = w;
            n_edges++;
          end
        end
        ACT_RUN: solve_paths();
        default: begin
          if (q < 1 || q > cnt) begin
            r.status = ST_BAD_NODE;
            r.distance = UNREACHED;
          end else if (reached[q]) begin
            r.distance = node_dist[q];
            r.reachable = 1;
          end else r.distance = UNREACHED;
        end
      endcase
      pending = {pending, r};
    endfunction

    // check one result beat against the oldest expectation
    task check_result(path_result_t got);
      path_result_t exp_r;
      if (pending.size() == 0) begin
        report("result with nothing expected");
        return;
      end
      exp_r = pending.pop_front();
      if (got.status !== exp_r.status)
        report($sformatf("status got %0d want %0d", got.status, exp_r.status));
      if (got.distance !== exp_r.distance)
        report($sformatf("distance got %0h want %0h", got.distance, exp_r.distance));
      if (got.reachable !== exp_r.reachable)
        report($sformatf("reachable got %0b want %0b", got.reachable, exp_r.reachable));
    endtask

    task report(string msg);
      errors++;
      $display("mismatch: %s", msg);
    endtask
  endclass

  logic clk_i = 0;
  logic rst_ni = 0;
  logic node_count_we_i = 0;
  logic [NODE_W-1:0] node_count_i = '0;
  longint cycles = 0;
  bit stall_en = 1;
  int res_wait = 0;

  ssp_in_if  req_if ();
  ssp_out_if res_if ();

  path_scoreboard sb = new();

  single_source_shortest_paths u_dut (
    .clk_i, .rst_ni, .node_count_we_i, .node_count_i,
    .in_i(req_if.sink), .out_o(res_if.source)
  );

  always begin
    #1 clk_i = 1;
    #1 clk_i = 0;
  end

  initial begin
    req_if.valid = 0;
    req_if.action = ACT_CLEAR;
    req_if.from_node = '0;
    req_if.to_node = '0;
    req_if.edge_weight = '0;
    req_if.query_node = '0;
    res_if.ready = 0;
  end

  // cycle limit
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // result side: random per-beat wait when stalls are enabled, check on each beat
  always @(posedge clk_i) begin
    if (res_if.valid && res_if.ready) begin
      sb.check_result({res_if.status, res_if.distance, res_if.reachable});
      res_wait = stall_en ? int'($urandom_range(0, 4)) : 0;
    end else if (res_wait > 0) begin
      res_wait--;
    end
    res_if.ready <= (res_wait == 0);
  end

  task automatic send_item(logic [1:0] act, logic [NODE_W-1:0] f, logic [NODE_W-1:0] t,
                           logic [WEIGHT_W-1:0] w, logic [NODE_W-1:0] q);
    int gap;
    gap = stall_en ? int'($urandom_range(0, 4)) : 0;
    if (gap > 0) begin
      req_if.valid <= 0;
      repeat (gap) @(posedge clk_i);
    end
    req_if.valid <= 1;
    req_if.action <= act;
    req_if.from_node <= f;
    req_if.to_node <= t;
    req_if.edge_weight <= w;
    req_if.query_node <= q;
    do @(posedge clk_i); while (!req_if.ready);
    sb.note_item(act, f, t, w, q);
  endtask

  task automatic drain();
    req_if.valid <= 0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic set_nodes(logic [NODE_W-1:0] n);
    drain();
    node_count_we_i <= 1;
    node_count_i <= n;
    @(posedge clk_i);
    node_count_we_i <= 0;
    sb.nodes = n;
  endtask

  function automatic logic [WEIGHT_W-1:0] rand_weight();
    case ($urandom_range(0, 3))
      0: return 32'hFFFF_FFFF - $urandom_range(0, 3);
      1: return $urandom_range(0, 3);
      default: return $urandom;
    endcase
  endfunction

  // one random graph: clear, edges, run, queries
  task automatic random_graph(int n);
    int ne;
    set_nodes(n[NODE_W-1:0]);
    send_item(ACT_CLEAR, NODE_W'($urandom), NODE_W'($urandom), $urandom, NODE_W'($urandom));
    ne = $urandom_range(0, 3 * n);
    for (int i = 0; i < ne; i++) begin
      if ($urandom_range(0, 9) == 0)
        send_item(ACT_LOAD, NODE_W'($urandom), NODE_W'($urandom), rand_weight(),
                  NODE_W'($urandom));
      else
        send_item(ACT_LOAD, NODE_W'($urandom_range(1, n)), NODE_W'($urandom_range(1, n + 1)),
                  rand_weight(), NODE_W'($urandom));
    end
    send_item(ACT_RUN, NODE_W'($urandom), NODE_W'($urandom), $urandom, NODE_W'($urandom));
    for (int i = 0; i < n + 2; i++)
      send_item(ACT_QUERY, NODE_W'($urandom), NODE_W'($urandom), $urandom,
                NODE_W'(($urandom_range(0, 7) == 0) ? $urandom : $urandom_range(0, n + 1)));
  endtask

  initial begin
    int total;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    // directed: queries before any run at the reset node count
    send_item(ACT_QUERY, 0, 0, 0, 1);
    send_item(ACT_QUERY, 0, 0, 0, 1024);
    send_item(ACT_QUERY, 0, 0, 0, 0);
    send_item(ACT_QUERY, 0, 0, 0, 11'h7FF);
    // bad loads: zero and oversized nodes
    send_item(ACT_LOAD, 0, 2, 5, 0);
    send_item(ACT_LOAD, 1025, 2, 5, 0);
    send_item(ACT_LOAD, 2, 11'h7FF, 5, 0);
    // extreme weights, largest node
    send_item(ACT_LOAD, 1, 1024, 32'hFFFF_FFFF, 0);
    send_item(ACT_LOAD, 1024, 2, 32'hFFFF_FFFF, 0);
    send_item(ACT_LOAD, 1, 2, 0, 0);
    send_item(ACT_RUN, 0, 0, 0, 0);
    send_item(ACT_QUERY, 0, 0, 0, 2);
    send_item(ACT_QUERY, 0, 0, 0, 1024);
    send_item(ACT_QUERY, 0, 0, 0, 3);
    // count shrinks after a run: stale edges and nodes
    set_nodes(3);
    send_item(ACT_QUERY, 0, 0, 0, 1024);
    send_item(ACT_QUERY, 0, 0, 0, 2);
    send_item(ACT_RUN, 0, 0, 0, 0);
    send_item(ACT_QUERY, 0, 0, 0, 2);
    // zero nodes: everything out of range
    set_nodes(0);
    send_item(ACT_LOAD, 1, 1, 1, 0);
    send_item(ACT_RUN, 0, 0, 0, 0);
    send_item(ACT_QUERY, 0, 0, 0, 1);
    // count above the maximum acts as the maximum
    set_nodes(11'h7FF);
    send_item(ACT_QUERY, 0, 0, 0, 1024);
    send_item(ACT_QUERY, 0, 0, 0, 1025);
    send_item(ACT_CLEAR, 0, 0, 0, 0);

    // full store: fill with small nodes, then overflow
    set_nodes(2);
    for (int i = 0; i < MAX_EDGES; i++)
      send_item(ACT_LOAD, NODE_W'($urandom_range(1, 2)), NODE_W'($urandom_range(1, 2)),
                $urandom, 0);
    send_item(ACT_LOAD, 1, 2, 7, 0);
    send_item(ACT_LOAD, 5, 2, 7, 0);
    send_item(ACT_RUN, 0, 0, 0, 0);
    send_item(ACT_QUERY, 0, 0, 0, 2);
    send_item(ACT_CLEAR, 0, 0, 0, 0);

    // random graphs; idling is switched off at random for about one graph in six
    total = 0;
    while (total < 1500) begin
      int n;
      stall_en = ($urandom_range(0, 5) != 0);
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 40) : $urandom_range(1, 8);
      random_graph(n);
      total += 4 * n + 4;
    end
    stall_en = 1;
    // one run at the largest count
    random_graph(1024);

    drain();
    if (sb.errors == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end
endmodule
`default_nettype wire

[single_source_shortest_paths.f]
+incdir+rtl
rtl/ssp_pkg.sv
rtl/ssp_in_if.sv
rtl/ssp_out_if.sv
rtl/ssp_ram.sv
rtl/single_source_shortest_paths.sv
sim/single_source_shortest_paths_tb.sv
